/* rtl/c_subset_lexer_top_assert.svh */
// assertion macros for the c subset lexer checker
// each expects clk and rst_n in the scope where it is used
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// condition and consequence in the same cycle
`define CLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the following cycle
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/clp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg
// shared types, codes and helper functions of the c subset lexer
// ----------------------------------------------------------------------------
package clp_pkg;

  // position counter width and queue depth
  localparam int POSITION_BITS = 16;
  localparam int QDEPTH        = 4;
  localparam int LEN_BITS      = 16;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LEN_BITS-1:0]      len_t;

  // token kinds as seen on the result channel
  typedef enum logic [3:0] {
    KIND_INTEGER = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_INT     = 4'd2,
    KIND_RETURN  = 4'd3,
    KIND_LBRACE  = 4'd4,
    KIND_RBRACE  = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_EOF     = 4'd9,
    KIND_ERROR   = 4'd10
  } kind_t;

  // character classes decided by the front end
  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_SINGLE
  } cls_t;

  // character codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_LOWER_I    = 8'h69;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_LOWER_R    = 8'h72;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;
  localparam logic [7:0] CH_LOWER_U    = 8'h75;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // keyword tracker codes: prefixes of int and return
  typedef logic [3:0] kw_t;
  localparam kw_t KW_NONE   = 4'd0;
  localparam kw_t KW_I      = 4'd1;
  localparam kw_t KW_IN     = 4'd2;
  localparam kw_t KW_INT    = 4'd3;
  localparam kw_t KW_R      = 4'd4;
  localparam kw_t KW_RE     = 4'd5;
  localparam kw_t KW_RET    = 4'd6;
  localparam kw_t KW_RETU   = 4'd7;
  localparam kw_t KW_RETUR  = 4'd8;
  localparam kw_t KW_RETURN = 4'd9;

  // item as queued between front and back
  typedef struct packed {
    logic       eop;
    logic [7:0] ch;
    cls_t       cls;
    kind_t      kind;
  } clp_item_t;

  // push from the front end into the queue
  typedef struct packed {
    logic      valid;
    clp_item_t item;
  } clp_push_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } clp_result_t;

  // tracker value at the start of an identifier
  function automatic kw_t kw_first(input logic [7:0] ch);
    kw_t t;
    t = KW_NONE;
    if (ch == CH_LOWER_I) t = KW_I;
    else if (ch == CH_LOWER_R) t = KW_R;
    return t;
  endfunction

  // tracker step on a further identifier character
  function automatic kw_t kw_next(input kw_t t, input logic [7:0] ch);
    kw_t n;
    n = KW_NONE;
    case (t)
      KW_I:     if (ch == CH_LOWER_N) n = KW_IN;
      KW_IN:    if (ch == CH_LOWER_T) n = KW_INT;
      KW_R:     if (ch == CH_LOWER_E) n = KW_RE;
      KW_RE:    if (ch == CH_LOWER_T) n = KW_RET;
      KW_RET:   if (ch == CH_LOWER_U) n = KW_RETU;
      KW_RETU:  if (ch == CH_LOWER_R) n = KW_RETUR;
      KW_RETUR: if (ch == CH_LOWER_N) n = KW_RETURN;
      default:  n = KW_NONE;
    endcase
    return n;
  endfunction

endpackage

/* rtl/clp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_in_if
// source character channel: valid/ready with command and byte
// ----------------------------------------------------------------------------
interface clp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] character;

  modport source (output valid, output cmd, output character, input ready);
  modport sink   (input valid, input cmd, input character, output ready);
endinterface

/* rtl/clp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_out_if
// token channel: valid/ready with kind, position, length and end marker
// ----------------------------------------------------------------------------
interface clp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output line_number,
                  output column_number, output token_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input line_number,
                  input column_number, input token_length,
                  input last_of_run, output ready);
endinterface

/* rtl/clp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_front
// accepts source items and classifies each byte before queueing it
// ----------------------------------------------------------------------------
module clp_front (
  clp_in_if.sink                in_ch,
  input  logic                  q_full,
  output clp_pkg::clp_push_t    push
);

  clp_pkg::clp_item_t item;

  // take an item whenever the queue has room
  assign in_ch.ready = !q_full;

  // byte classification in the c locale
  always_comb begin
    item.eop  = in_ch.cmd;
    item.ch   = in_ch.character;
    item.kind = clp_pkg::KIND_ERROR;
    if (in_ch.character == clp_pkg::CH_SPACE ||
        (in_ch.character >= clp_pkg::CH_TAB && in_ch.character <= clp_pkg::CH_CR)) begin
      item.cls = (in_ch.character == clp_pkg::CH_NEWLINE) ?
                 clp_pkg::CLS_NEWLINE : clp_pkg::CLS_SPACE;
    end else if (in_ch.character >= clp_pkg::CH_ZERO &&
                 in_ch.character <= clp_pkg::CH_NINE) begin
      item.cls = clp_pkg::CLS_DIGIT;
    end else if ((in_ch.character >= clp_pkg::CH_LOWER_A &&
                  in_ch.character <= clp_pkg::CH_LOWER_Z) ||
                 (in_ch.character >= clp_pkg::CH_UPPER_A &&
                  in_ch.character <= clp_pkg::CH_UPPER_Z) ||
                 in_ch.character == clp_pkg::CH_UNDERSCORE) begin
      item.cls = clp_pkg::CLS_ALPHA;
    end else begin
      item.cls = clp_pkg::CLS_SINGLE;
    end

    // punctuation decode, anything else is an error token
    unique case (in_ch.character)
      clp_pkg::CH_LBRACE: item.kind = clp_pkg::KIND_LBRACE;
      clp_pkg::CH_RBRACE: item.kind = clp_pkg::KIND_RBRACE;
      clp_pkg::CH_LPAREN: item.kind = clp_pkg::KIND_LPAREN;
      clp_pkg::CH_RPAREN: item.kind = clp_pkg::KIND_RPAREN;
      clp_pkg::CH_SEMI:   item.kind = clp_pkg::KIND_SEMI;
      default:            item.kind = clp_pkg::KIND_ERROR;
    endcase
  end

  assign push.valid = in_ch.valid && !q_full;
  assign push.item  = item;

endmodule

/* rtl/clp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module clp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  clp_pkg::clp_push_t  push,
  output logic                full,
  input  logic                pop,
  output clp_pkg::clp_item_t  pop_item,
  output logic                empty
);

  localparam int PTR_W = $clog2(clp_pkg::QDEPTH);
  localparam int CNT_W = $clog2(clp_pkg::QDEPTH + 1);

  clp_pkg::clp_item_t mem [clp_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W'(clp_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(clp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(clp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.item;
  end

endmodule

/* rtl/clp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_back
// lexer state, token building and the two-entry result output stage
// ----------------------------------------------------------------------------
module clp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  clp_pkg::clp_item_t  q_item,
  output logic                q_pop,
  clp_out_if.source           out_ch
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT
  } mode_t;

  mode_t              mode_r, mode_nxt;
  clp_pkg::pos_t      line_r, line_nxt;
  clp_pkg::pos_t      col_r, col_nxt;
  clp_pkg::pos_t      start_r, start_nxt;
  clp_pkg::len_t      len_r, len_nxt;
  clp_pkg::kw_t       kw_r, kw_nxt;

  logic               out_v_r, out_v_nxt;
  logic               hold_v_r, hold_v_nxt;
  clp_pkg::clp_result_t out_d_r, out_d_nxt;
  clp_pkg::clp_result_t hold_d_r, hold_d_nxt;

  logic               out_free;
  logic               has_flush, has_own;
  clp_pkg::clp_result_t flush_res, own_res, res0, res1;
  clp_pkg::pos_t      col_inc, line_inc;
  clp_pkg::len_t      len_inc;

  // saturating increments
  assign col_inc  = (col_r == '1) ? col_r : col_r + 1'b1;
  assign line_inc = (line_r == '1) ? line_r : line_r + 1'b1;
  assign len_inc  = (len_r == '1) ? len_r : len_r + 1'b1;

  // take the next item only when nothing is left over from the last one
  assign out_free = !out_v_r || out_ch.ready;
  assign q_pop    = !q_empty && !hold_v_r && out_free;

  // token of the pending run
  always_comb begin
    flush_res.line = 16'(line_r);
    flush_res.col  = 16'(start_r);
    flush_res.len  = 16'(len_r);
    flush_res.last = 1'b0;
    if (mode_r == MODE_NUM)               flush_res.kind = clp_pkg::KIND_INTEGER;
    else if (kw_r == clp_pkg::KW_INT)     flush_res.kind = clp_pkg::KIND_INT;
    else if (kw_r == clp_pkg::KW_RETURN)  flush_res.kind = clp_pkg::KIND_RETURN;
    else                                  flush_res.kind = clp_pkg::KIND_IDENT;
  end

  // lexer step on the popped item
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    kw_nxt    = kw_r;
    has_flush = 1'b0;
    has_own   = 1'b0;
    own_res.kind = q_item.kind;
    own_res.line = 16'(line_r);
    own_res.col  = 16'(col_r);
    own_res.len  = 16'd1;
    own_res.last = 1'b1;
    if (q_pop) begin
      if (q_item.eop) begin
        // flush, end of source, back to the reset state
        has_flush    = (mode_r != MODE_IDLE);
        has_own      = 1'b1;
        own_res.kind = clp_pkg::KIND_EOF;
        own_res.len  = 16'd0;
        mode_nxt     = MODE_IDLE;
        line_nxt     = clp_pkg::pos_t'(1);
        col_nxt      = clp_pkg::pos_t'(1);
        start_nxt    = clp_pkg::pos_t'(1);
        len_nxt      = '0;
        kw_nxt       = clp_pkg::KW_NONE;
      end else if (mode_r == MODE_NUM && q_item.cls == clp_pkg::CLS_DIGIT) begin
        len_nxt = len_inc;
        col_nxt = col_inc;
      end else if (mode_r == MODE_IDENT && (q_item.cls == clp_pkg::CLS_DIGIT ||
                                            q_item.cls == clp_pkg::CLS_ALPHA)) begin
        len_nxt = len_inc;
        kw_nxt  = clp_pkg::kw_next(kw_r, q_item.ch);
        col_nxt = col_inc;
      end else begin
        // the run ends here, then the byte itself
        has_flush = (mode_r != MODE_IDLE);
        mode_nxt  = MODE_IDLE;
        len_nxt   = '0;
        kw_nxt    = clp_pkg::KW_NONE;
        case (q_item.cls)
          clp_pkg::CLS_NEWLINE: begin
            line_nxt = line_inc;
            col_nxt  = clp_pkg::pos_t'(1);
          end
          clp_pkg::CLS_SPACE: begin
            col_nxt = col_inc;
          end
          clp_pkg::CLS_DIGIT: begin
            mode_nxt  = MODE_NUM;
            start_nxt = col_r;
            len_nxt   = clp_pkg::len_t'(1);
            col_nxt   = col_inc;
          end
          clp_pkg::CLS_ALPHA: begin
            mode_nxt  = MODE_IDENT;
            start_nxt = col_r;
            len_nxt   = clp_pkg::len_t'(1);
            kw_nxt    = clp_pkg::kw_first(q_item.ch);
            col_nxt   = col_inc;
          end
          default: begin
            has_own = 1'b1;
            col_nxt = col_inc;
          end
        endcase
      end
    end
  end

  // order the results of one item
  always_comb begin
    res0      = has_flush ? flush_res : own_res;
    res0.last = !(has_flush && has_own);
    res1      = own_res;
  end

  // output register and the second-result hold stage
  always_comb begin
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_d_nxt  = out_d_r;
    hold_v_nxt = hold_v_r;
    hold_d_nxt = hold_d_r;
    if (hold_v_r && out_free) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = hold_d_r;
      hold_v_nxt = 1'b0;
    end else if (has_flush || has_own) begin
      out_v_nxt = 1'b1;
      out_d_nxt = res0;
      if (has_flush && has_own) begin
        hold_v_nxt = 1'b1;
        hold_d_nxt = res1;
      end
    end
  end

  // lexer state, result valids and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      line_r   <= clp_pkg::pos_t'(1);
      col_r    <= clp_pkg::pos_t'(1);
      start_r  <= clp_pkg::pos_t'(1);
      len_r    <= '0;
      kw_r     <= clp_pkg::KW_NONE;
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      kw_r     <= kw_nxt;
      out_v_r  <= out_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    hold_d_r <= hold_d_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.token_kind    = out_d_r.kind;
  assign out_ch.line_number   = out_d_r.line;
  assign out_ch.column_number = out_d_r.col;
  assign out_ch.token_length  = out_d_r.len;
  assign out_ch.last_of_run   = out_d_r.last;

endmodule

/* rtl/c_subset_lexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer_top
// tokenizer for a small c subset, one source byte per item
// ----------------------------------------------------------------------------
// in_ch carries one source byte per item (cmd 0) or the end of source
// (cmd 1). out_ch carries tokens: kind, start line and column, length and
// a marker on the last token caused by an input item.
// a token is stored in the queue, then in the output register of the back
// end, before it appears on out_ch.
// throughput: one item per cycle while the queue has room; an item that
// yields two tokens (a run ended by punctuation, an error byte or end of
// source) holds the back end while its second token waits in the hold
// stage behind the output register. a four-entry queue between classifier
// and lexer absorbs that, so the input keeps flowing for a few such items.
// reset (rst_n low, synchronous) empties the queue and the output stage
// and returns to line 1, column 1 with no run pending.
// when the receiver stalls the token holds on out_ch, the queue fills and
// in_ch.ready drops once it is full.
// ----------------------------------------------------------------------------
module c_subset_lexer_top (
  input  logic       clk,
  input  logic       rst_n,
  clp_in_if.sink     in_ch,
  clp_out_if.source  out_ch
);

  clp_pkg::clp_push_t push;
  clp_pkg::clp_item_t q_item;
  logic               q_full, q_empty, q_pop;

  // byte classification
  clp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // decoupling queue
  clp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .pop      (q_pop),
    .pop_item (q_item),
    .empty    (q_empty)
  );

  // lexer and result stage
  clp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/clp_checker.sv */
`timescale 1ns / 1ps
`include "c_subset_lexer_top_assert.svh"
// ----------------------------------------------------------------------------
// clp_checker
// port level checks on the token channel of the lexer
// ----------------------------------------------------------------------------
module clp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [15:0] out_line,
  input logic [15:0] out_col,
  input logic [15:0] out_len,
  input logic        out_last
);

  logic is_single;

  // punctuation and error tokens are one byte long
  assign is_single = (out_kind == clp_pkg::KIND_LBRACE) ||
                     (out_kind == clp_pkg::KIND_RBRACE) ||
                     (out_kind == clp_pkg::KIND_LPAREN) ||
                     (out_kind == clp_pkg::KIND_RPAREN) ||
                     (out_kind == clp_pkg::KIND_SEMI)   ||
                     (out_kind == clp_pkg::KIND_ERROR);

  // a stalled token stays put
  `CLP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable({out_kind, out_line, out_col, out_len, out_last}), "token changed under stall")

  // end of source is always the final token of its item and empty
  `CLP_ASSERT_SAME(a_eof_last, out_valid && out_kind == clp_pkg::KIND_EOF, out_last && out_len == 16'd0, "bad eof token")

  // single byte tokens close their item and have length one
  `CLP_ASSERT_SAME(a_single_len, out_valid && is_single, out_last && out_len == 16'd1, "bad single token")

  // the second token of an item follows right after the first
  `CLP_ASSERT_NEXT(a_pair_follow, out_valid && out_ready && !out_last, out_valid, "second token missing")

  // positions start at one
  `CLP_ASSERT_SAME(a_pos_nonzero, out_valid, out_line != 16'd0 && out_col != 16'd0, "zero position")

endmodule

bind c_subset_lexer_top clp_checker u_clp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.token_kind),
  .out_line  (out_ch.line_number),
  .out_col   (out_ch.column_number),
  .out_len   (out_ch.token_length),
  .out_last  (out_ch.last_of_run)
);

/* bench/tb_c_subset_lexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_subset_lexer_top
// self-checking bench for the c subset lexer
// ----------------------------------------------------------------------------
// A short table of directed characters comes first. A few of its rows carry a
// hand-written token; every other row is checked against the lexer model
// below. Random phrases follow: keywords and near-keywords,
// identifiers, numbers, punctuation, white space, stray bytes and end
// markers. The sender works in bursts with random gaps. The receiver
// switches among free, random, periodic and long stall styles. Every token
// is compared field by field with the oldest token still due.
// ----------------------------------------------------------------------------
module tb_c_subset_lexer_top;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 1400;
  localparam int TAIL_CYCLES  = 10;

  localparam clp_pkg::pos_t POS_TOP = '1;
  localparam clp_pkg::len_t LEN_TOP = '1;

  localparam logic [8*3-1:0] WORD_INT    = "int";
  localparam logic [8*6-1:0] WORD_RETURN = "return";

  typedef enum logic [1:0] {RUN_IDLE, RUN_NUMBER, RUN_WORD} run_t;
  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PERIODIC, DRAIN_LONG} drain_t;

  // one directed row; the token columns matter only when pin is set
  typedef struct packed {
    logic            cmd;
    logic [7:0]      ch;
    logic            pin;
    clp_pkg::kind_t  kind;
    logic [15:0]     line;
    logic [15:0]     col;
    logic [15:0]     len;
  } dir_row_t;

  // one item waiting to be sent
  typedef struct {
    logic                 cmd;
    logic [7:0]           ch;
    bit                   steady;
    bit                   pin;
    clp_pkg::clp_result_t pinned;
  } feed_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_CHAR, clp_pkg::CH_LPAREN, 1'b1, clp_pkg::KIND_LPAREN, 16'd1, 16'd1, 16'd1},
    '{CMD_CHAR, 8'h00, 1'b1, clp_pkg::KIND_ERROR, 16'd1, 16'd2, 16'd1},
    '{CMD_CHAR, 8'hFF, 1'b1, clp_pkg::KIND_ERROR, 16'd1, 16'd3, 16'd1},
    '{CMD_CHAR, clp_pkg::CH_LOWER_I, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_N, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_T, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_SPACE, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_R, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_E, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_T, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_U, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_R, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LOWER_N, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_SEMI, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_NINE, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_UPPER_Z, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_UNDERSCORE, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_NEWLINE, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_LBRACE, 1'b1, clp_pkg::KIND_LBRACE, 16'd2, 16'd1, 16'd1},
    '{CMD_CHAR, clp_pkg::CH_RBRACE, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_RPAREN, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_ZERO, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_END,  8'hFF, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0},
    '{CMD_END,  8'h00, 1'b1, clp_pkg::KIND_EOF, 16'd1, 16'd1, 16'd0},
    '{CMD_CHAR, clp_pkg::CH_CR, 1'b0, clp_pkg::KIND_INTEGER, 16'd0, 16'd0, 16'd0}
  };

  logic clk;
  logic rst_n;

  clp_in_if  in_ch ();
  clp_out_if out_ch ();

  c_subset_lexer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  feed_t                feed_q [$];
  clp_pkg::clp_result_t tokens_due [$];
  clp_pkg::clp_result_t lex_out [$];
  int                   fed_count;
  int                   err_count;

  string kw_bait [8] = '{"int", "return", "in", "i", "retur", "re", "intx", "returnz"};

  // lexer model state
  run_t          lx_mode;
  clp_pkg::pos_t lx_line;
  clp_pkg::pos_t lx_col;
  clp_pkg::pos_t lx_start;
  clp_pkg::len_t lx_len;
  clp_pkg::kw_t  lx_kw;

  // ---------------------------------------------------------------- model

  function automatic clp_pkg::pos_t pos_bump(clp_pkg::pos_t v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  function automatic clp_pkg::len_t len_bump(clp_pkg::len_t v);
    return (v == LEN_TOP) ? v : v + 1'b1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= clp_pkg::CH_LOWER_A && c <= clp_pkg::CH_LOWER_Z) ||
           (c >= clp_pkg::CH_UPPER_A && c <= clp_pkg::CH_UPPER_Z);
  endfunction

  // keyword prefix tracking: within each keyword the code steps up by one per matched letter
  function automatic clp_pkg::kw_t kw_follow(clp_pkg::kw_t t, logic [7:0] c);
    int ti;
    ti = int'(t);
    if (t >= clp_pkg::KW_I && t < clp_pkg::KW_INT && c == WORD_INT[8*(2-ti) +: 8])
      return t + 1'b1;
    if (t >= clp_pkg::KW_R && t < clp_pkg::KW_RETURN && c == WORD_RETURN[8*(8-ti) +: 8])
      return t + 1'b1;
    return clp_pkg::KW_NONE;
  endfunction

  function automatic void lex_restart();
    lx_mode  = RUN_IDLE;
    lx_line  = clp_pkg::pos_t'(1);
    lx_col   = clp_pkg::pos_t'(1);
    lx_start = clp_pkg::pos_t'(1);
    lx_len   = '0;
    lx_kw    = clp_pkg::KW_NONE;
  endfunction

  function automatic void emit_token(clp_pkg::kind_t k, clp_pkg::pos_t ln,
                                     clp_pkg::pos_t cl, clp_pkg::len_t n);
    clp_pkg::clp_result_t t;
    t.kind = k;
    t.line = 16'(ln);
    t.col  = 16'(cl);
    t.len  = 16'(n);
    t.last = 1'b0;
    lex_out.push_back(t);
  endfunction

  // a pending number or word becomes a token
  function automatic void flush_run();
    clp_pkg::kind_t k;
    if (lx_mode == RUN_IDLE) return;
    if (lx_mode == RUN_NUMBER) k = clp_pkg::KIND_INTEGER;
    else if (lx_kw == clp_pkg::KW_INT) k = clp_pkg::KIND_INT;
    else if (lx_kw == clp_pkg::KW_RETURN) k = clp_pkg::KIND_RETURN;
    else k = clp_pkg::KIND_IDENT;
    emit_token(k, lx_line, lx_start, lx_len);
    lx_mode = RUN_IDLE;
    lx_len  = '0;
    lx_kw   = clp_pkg::KW_NONE;
  endfunction

  // tokens caused by one accepted item land in lex_out
  function automatic void lex_predict(logic cmd, logic [7:0] c);
    clp_pkg::kind_t k;
    lex_out.delete();
    if (cmd == CMD_END) begin
      flush_run();
      emit_token(clp_pkg::KIND_EOF, lx_line, lx_col, '0);
      lex_restart();
    end else if (lx_mode == RUN_NUMBER && is_digit(c)) begin
      lx_len = len_bump(lx_len);
      lx_col = pos_bump(lx_col);
    end else if (lx_mode == RUN_WORD &&
                 (is_alpha(c) || is_digit(c) || c == clp_pkg::CH_UNDERSCORE)) begin
      lx_len = len_bump(lx_len);
      lx_kw  = kw_follow(lx_kw, c);
      lx_col = pos_bump(lx_col);
    end else begin
      flush_run();
      if (c == clp_pkg::CH_NEWLINE) begin
        lx_line = pos_bump(lx_line);
        lx_col  = clp_pkg::pos_t'(1);
      end else if (c == clp_pkg::CH_SPACE ||
                   (c >= clp_pkg::CH_TAB && c <= clp_pkg::CH_CR)) begin
        lx_col = pos_bump(lx_col);
      end else if (is_digit(c) || is_alpha(c) || c == clp_pkg::CH_UNDERSCORE) begin
        lx_mode  = is_digit(c) ? RUN_NUMBER : RUN_WORD;
        lx_start = lx_col;
        lx_len   = clp_pkg::len_t'(1);
        if (lx_mode == RUN_WORD && c == clp_pkg::CH_LOWER_I) lx_kw = clp_pkg::KW_I;
        else if (lx_mode == RUN_WORD && c == clp_pkg::CH_LOWER_R) lx_kw = clp_pkg::KW_R;
        else lx_kw = clp_pkg::KW_NONE;
        lx_col = pos_bump(lx_col);
      end else begin
        case (c)
          clp_pkg::CH_LBRACE: k = clp_pkg::KIND_LBRACE;
          clp_pkg::CH_RBRACE: k = clp_pkg::KIND_RBRACE;
          clp_pkg::CH_LPAREN: k = clp_pkg::KIND_LPAREN;
          clp_pkg::CH_RPAREN: k = clp_pkg::KIND_RPAREN;
          clp_pkg::CH_SEMI:   k = clp_pkg::KIND_SEMI;
          default:            k = clp_pkg::KIND_ERROR;
        endcase
        emit_token(k, lx_line, lx_col, clp_pkg::len_t'(1));
        lx_col = pos_bump(lx_col);
      end
    end
    if (lex_out.size() != 0) lex_out[lex_out.size()-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic void push_item(logic cmd, logic [7:0] c, bit steady);
    feed_t f;
    f.cmd    = cmd;
    f.ch     = c;
    f.steady = steady;
    f.pin    = 1'b0;
    f.pinned = '0;
    feed_q.push_back(f);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(CMD_CHAR, s[i], 1'b0);
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 6 : 9);
    if (r < 3) return 8'($urandom_range(clp_pkg::CH_LOWER_A, clp_pkg::CH_LOWER_Z));
    if (r < 5) return 8'($urandom_range(clp_pkg::CH_UPPER_A, clp_pkg::CH_UPPER_Z));
    if (r < 6 || lead) return clp_pkg::CH_UNDERSCORE;
    return 8'($urandom_range(clp_pkg::CH_ZERO, clp_pkg::CH_NINE));
  endfunction

  // one random phrase; mostly well-formed tokens, some noise
  function automatic void push_phrase();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      push_text(kw_bait[$urandom_range(0, 7)]);
    end else if (pick < 32) begin
      n = $urandom_range(1, 9);
      push_item(CMD_CHAR, word_char(1'b1), 1'b0);
      for (int i = 1; i < n; i++) push_item(CMD_CHAR, word_char(1'b0), 1'b0);
    end else if (pick < 46) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        push_item(CMD_CHAR, 8'($urandom_range(clp_pkg::CH_ZERO, clp_pkg::CH_NINE)), 1'b0);
    end else if (pick < 64) begin
      case ($urandom_range(0, 4))
        0:       push_item(CMD_CHAR, clp_pkg::CH_LBRACE, 1'b0);
        1:       push_item(CMD_CHAR, clp_pkg::CH_RBRACE, 1'b0);
        2:       push_item(CMD_CHAR, clp_pkg::CH_LPAREN, 1'b0);
        3:       push_item(CMD_CHAR, clp_pkg::CH_RPAREN, 1'b0);
        default: push_item(CMD_CHAR, clp_pkg::CH_SEMI, 1'b0);
      endcase
    end else if (pick < 84) begin
      case ($urandom_range(0, 3))
        0:       push_item(CMD_CHAR, clp_pkg::CH_SPACE, 1'b0);
        1:       push_item(CMD_CHAR, clp_pkg::CH_NEWLINE, 1'b0);
        default: push_item(CMD_CHAR, 8'($urandom_range(clp_pkg::CH_TAB, clp_pkg::CH_CR)), 1'b0);
      endcase
    end else if (pick < 96) begin
      push_item(CMD_CHAR, 8'($urandom_range(0, 255)), 1'b0);
    end else begin
      push_item(CMD_END, 8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  // ------------------------------------------------------------ checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender: bursts of items with random gaps, none in steady stretches
  initial begin : feeder
    int drv_idx;
    int burst_left;
    int gap_left;
    bit fire;
    drv_idx    = 0;
    burst_left = 0;
    gap_left   = 0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_CHAR;
    in_ch.character <= '0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      fire = in_ch.valid && in_ch.ready;
      if (fire) drv_idx++;
      if (in_ch.valid && !fire) begin
        // item still on offer
      end else if (drv_idx >= feed_q.size()) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0 && !feed_q[drv_idx].steady) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= feed_q[drv_idx].cmd;
        in_ch.character <= feed_q[drv_idx].ch;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: switches among free, random, periodic and long stall styles
  initial begin : drain
    drain_t style;
    int     cyc;
    int     hold_left;
    style     = DRAIN_FREE;
    cyc       = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 300 == 0) style = drain_t'($urandom_range(0, 3));
      case (style)
        DRAIN_FREE:     out_ch.ready <= 1'b1;
        DRAIN_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        DRAIN_PERIODIC: out_ch.ready <= ((cyc % 5) < 2);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // scoreboard: predict on accepted items, compare accepted tokens
  always @(posedge clk) begin : scoreboard
    clp_pkg::clp_result_t want;
    feed_t                rec;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (tokens_due.size() == 0) begin
          $error("token with none due: kind %0d line %0d column %0d", out_ch.token_kind,
                 out_ch.line_number, out_ch.column_number);
          err_count++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(out_ch.token_kind));
          check_field("line_number", 32'(want.line), 32'(out_ch.line_number));
          check_field("column_number", 32'(want.col), 32'(out_ch.column_number));
          check_field("token_length", 32'(want.len), 32'(out_ch.token_length));
          check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        rec = feed_q[fed_count];
        fed_count++;
        lex_predict(rec.cmd, rec.ch);
        if (rec.pin) tokens_due.push_back(rec.pinned);
        else foreach (lex_out[i]) tokens_due.push_back(lex_out[i]);
      end
    end
  end

  // main sequence
  initial begin : main
    feed_t f;
    int    random_start;
    fed_count = 0;
    err_count = 0;
    rst_n <= 1'b0;
    lex_restart();

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      f.cmd         = DIRECTED[i].cmd;
      f.ch          = DIRECTED[i].ch;
      f.steady      = 1'b0;
      f.pin         = DIRECTED[i].pin;
      f.pinned.kind = DIRECTED[i].kind;
      f.pinned.line = DIRECTED[i].line;
      f.pinned.col  = DIRECTED[i].col;
      f.pinned.len  = DIRECTED[i].len;
      f.pinned.last = 1'b1;
      feed_q.push_back(f);
    end

    // punctuation, a high byte and a word closed by an end item
    push_item(CMD_CHAR, clp_pkg::CH_RPAREN, 1'b0);
    push_item(CMD_CHAR, 8'h80, 1'b0);
    push_item(CMD_CHAR, clp_pkg::CH_LOWER_I, 1'b0);
    push_item(CMD_END, clp_pkg::CH_SEMI, 1'b0);

    // random phrases, closed by an end item
    random_start = feed_q.size();
    while (feed_q.size() < random_start + N_RANDOM) push_phrase();
    push_item(CMD_END, 8'($urandom_range(0, 255)), 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (fed_count < feed_q.size() || tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/clp_pkg.sv
rtl/clp_in_if.sv
rtl/clp_out_if.sv
rtl/clp_front.sv
rtl/clp_fifo.sv
rtl/clp_back.sv
rtl/c_subset_lexer_top.sv
rtl/clp_checker.sv
bench/tb_c_subset_lexer_top.sv
